FILE: src/rar_pkg.sv
package rar_pkg;

  // operation selector carried in the input tuser
  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  // result status carried in the output tuser
  localparam logic [1:0] STATUS_FRACTION = 2'd0;
  localparam logic [1:0] STATUS_WHOLE    = 2'd1;
  localparam logic [1:0] STATUS_UNDEF    = 2'd2;

  localparam int NUM_OUT_W = 33;
  localparam int DEN_OUT_W = 32;
  localparam int STATUS_W  = 2;
  localparam int KIND_W    = 2;

  // which product the shared multiplier forms this cycle
  typedef enum logic [1:0] {
    MUL_CROSS_A = 2'd0,
    MUL_CROSS_B = 2'd1,
    MUL_DEN     = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     comb;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
    logic     out_load;
  } rar_cmd_t;

  typedef struct packed {
    logic skip;
    logic gcd_done;
    logic div_done;
    logic out_free;
  } rar_sts_t;

endpackage

FILE: src/rar_ctrl.sv
module rar_ctrl import rar_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rar_sts_t sts_i,
  output rar_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL0 = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_COMB = 9'b000010000,
    S_GCD  = 9'b000100000,
    S_DIVI = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_CROSS_A;
        state_d       = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_CROSS_B;
        state_d       = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DEN;
        state_d       = S_COMB;
      end
      S_COMB: begin
        cmd_o.comb = 1'b1;
        state_d    = S_GCD;
      end
      S_GCD: begin
        if (sts_i.skip) begin
          state_d = S_OUT;
        end else if (sts_i.gcd_done) begin
          state_d = S_DIVI;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/rar_dp.sv
module rar_dp import rar_pkg::*; #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rar_cmd_t                      cmd_i,
  output rar_sts_t                      sts_o,
  input  kind_e                         kind_i,
  input  logic signed [OPERAND_BITS-1:0] num_a_i,
  input  logic        [OPERAND_BITS-1:0] den_a_i,
  input  logic signed [OPERAND_BITS-1:0] num_b_i,
  input  logic        [OPERAND_BITS-1:0] den_b_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [NUM_OUT_W-1:0]   num_out_o,
  output logic        [DEN_OUT_W-1:0]   den_out_o,
  output logic        [STATUS_W-1:0]    status_o
);

  localparam int OB = OPERAND_BITS;
  localparam int W  = 2 * OB;
  localparam int KW = $clog2(W + 1);
  localparam int EW = (W > 34) ? W : 34;
  localparam logic [EW-1:0] LIM_NEG = EW'(1) << 32;
  localparam logic [EW-1:0] LIM_POS = LIM_NEG - EW'(1);

  // operand registers, sign and magnitude
  kind_e         kind_q;
  logic          na_neg_q, nb_neg_q;
  logic [OB-1:0] na_mag_q, nb_mag_q, da_q, db_q;
  logic [OB-1:0] na_raw, nb_raw;

  // products
  logic [OB-1:0] mul_x, mul_y;
  logic [W-1:0]  prod_c;
  logic [W-1:0]  p0_q, p1_q, p2_q;

  // combined fraction
  logic          t_neg, sgn_c, den_neg_c;
  logic [W-1:0]  mag_c;
  logic          neg_q, den_zero_q, num_zero_q;

  // gcd and division
  logic [W-1:0]  a_q, a_d, b_q, b_d, g_q, g_c;
  logic [KW-1:0] k_q, k_d, cnt_q;
  logic [W-1:0]  nm_q, nm_d, dn_q, dn_d, rn_q, rn_d, rd_q, rd_d;
  logic [W:0]    rs_n, rs_d, sub_n, sub_d;
  logic          ge_n, ge_d;

  // output
  logic [EW-1:0]          nm_ext, dn_ext, nm_clamp;
  logic [NUM_OUT_W-1:0]   mag33;
  logic [NUM_OUT_W-1:0]   num_c;
  logic [DEN_OUT_W-1:0]   den_c;
  logic [STATUS_W-1:0]    status_c;
  logic                   out_valid_q;
  logic [NUM_OUT_W-1:0]   num_out_q;
  logic [DEN_OUT_W-1:0]   den_out_q;
  logic [STATUS_W-1:0]    status_q;

  assign na_raw = num_a_i;
  assign nb_raw = num_b_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      na_neg_q <= na_raw[OB-1];
      nb_neg_q <= nb_raw[OB-1];
      na_mag_q <= na_raw[OB-1] ? (~na_raw + OB'(1)) : na_raw;
      nb_mag_q <= nb_raw[OB-1] ? (~nb_raw + OB'(1)) : nb_raw;
      da_q     <= den_a_i;
      db_q     <= den_b_i;
    end
  end

  // one shared multiplier, operands picked by step and operation
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_CROSS_A: begin
        mul_x = na_mag_q;
        mul_y = (kind_q == KIND_MUL) ? nb_mag_q : db_q;
      end
      MUL_CROSS_B: begin
        mul_x = nb_mag_q;
        mul_y = da_q;
      end
      MUL_DEN: begin
        mul_x = (kind_q == KIND_DIV) ? nb_mag_q : da_q;
        mul_y = (kind_q == KIND_DIV) ? da_q : db_q;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign prod_c = W'(mul_x) * W'(mul_y);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      if (cmd_i.mul_sel == MUL_CROSS_A) p0_q <= prod_c;
      if (cmd_i.mul_sel == MUL_CROSS_B) p1_q <= prod_c;
      if (cmd_i.mul_sel == MUL_DEN)     p2_q <= prod_c;
    end
  end

  // signed-magnitude combine of the cross-products
  assign t_neg = nb_neg_q ^ (kind_q == KIND_SUB);

  always_comb begin
    den_neg_c = 1'b0;
    sgn_c     = na_neg_q;
    mag_c     = p0_q;
    case (kind_q) inside
      KIND_ADD, KIND_SUB: begin
        if (na_neg_q == t_neg) begin
          mag_c = p0_q + p1_q;
        end else if (p0_q >= p1_q) begin
          mag_c = p0_q - p1_q;
        end else begin
          sgn_c = t_neg;
          mag_c = p1_q - p0_q;
        end
      end
      KIND_MUL: begin
        sgn_c = na_neg_q ^ nb_neg_q;
      end
      default: begin
        den_neg_c = nb_neg_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.comb) begin
      neg_q      <= sgn_c ^ den_neg_c;
      den_zero_q <= (p2_q == '0);
      num_zero_q <= (mag_c == '0);
    end
  end

  // binary gcd, one step a cycle
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (cmd_i.comb) begin
      a_d = mag_c;
      b_d = p2_q;
      k_d = '0;
    end else if (cmd_i.gcd_step) begin
      if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + KW'(1);
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q > b_q) begin
        a_d = (a_q - b_q) >> 1;
      end else begin
        b_d = (b_q - a_q) >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
  end

  assign g_c = a_q << k_q;

  // two restoring dividers sharing the divisor, quotient shifts in place
  assign rs_n  = {rn_q, nm_q[W-1]};
  assign sub_n = rs_n - {1'b0, g_q};
  assign ge_n  = (rs_n >= {1'b0, g_q});
  assign rs_d  = {rd_q, dn_q[W-1]};
  assign sub_d = rs_d - {1'b0, g_q};
  assign ge_d  = (rs_d >= {1'b0, g_q});

  always_comb begin
    nm_d = nm_q;
    dn_d = dn_q;
    rn_d = rn_q;
    rd_d = rd_q;
    if (cmd_i.comb) begin
      nm_d = mag_c;
      dn_d = p2_q;
    end else if (cmd_i.div_init) begin
      rn_d = '0;
      rd_d = '0;
    end else if (cmd_i.div_step) begin
      nm_d = {nm_q[W-2:0], ge_n};
      dn_d = {dn_q[W-2:0], ge_d};
      rn_d = ge_n ? sub_n[W-1:0] : rs_n[W-1:0];
      rd_d = ge_d ? sub_d[W-1:0] : rs_d[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    nm_q <= nm_d;
    dn_q <= dn_d;
    rn_q <= rn_d;
    rd_q <= rd_d;
    if (cmd_i.div_init) g_q <= g_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + KW'(1);
    end
  end

  // saturate and format the result
  assign nm_ext   = EW'(nm_q);
  assign dn_ext   = EW'(dn_q);
  assign nm_clamp = neg_q ? ((nm_ext > LIM_NEG) ? LIM_NEG : nm_ext)
                          : ((nm_ext > LIM_POS) ? LIM_POS : nm_ext);
  assign mag33    = nm_clamp[NUM_OUT_W-1:0];

  always_comb begin
    if (den_zero_q) begin
      num_c    = '0;
      den_c    = '0;
      status_c = STATUS_UNDEF;
    end else if (num_zero_q) begin
      num_c    = '0;
      den_c    = DEN_OUT_W'(1);
      status_c = STATUS_WHOLE;
    end else begin
      num_c    = neg_q ? (~mag33 + NUM_OUT_W'(1)) : mag33;
      den_c    = (dn_ext > LIM_POS) ? LIM_POS[DEN_OUT_W-1:0] : dn_ext[DEN_OUT_W-1:0];
      status_c = (den_c == DEN_OUT_W'(1)) ? STATUS_WHOLE : STATUS_FRACTION;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      num_out_q <= num_c;
      den_out_q <= den_c;
      status_q  <= status_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.skip     = den_zero_q | num_zero_q;
  assign sts_o.gcd_done = a_q[0] & b_q[0] & (a_q == b_q);
  assign sts_o.div_done = (cnt_q == KW'(W));
  assign sts_o.out_free = !out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign num_out_o   = num_out_q;
  assign den_out_o   = den_out_q;
  assign status_o    = status_q;

  a_gcd_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gcd_step |-> (a_q != '0) && (b_q != '0))
    else $error("gcd operand reached zero");

  a_divisor_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |-> (g_c != '0))
    else $error("zero divisor at division start");

  a_reduced_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && !den_zero_q && !num_zero_q) |-> (dn_q != '0))
    else $error("reduced denominator is zero");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_i.out_load)
    else $error("result register overwritten while held");

endmodule

FILE: src/rational_arith_reduce.sv
// rational_arith_reduce: adds, subtracts, multiplies or divides two fractions
// (signed numerator, unsigned denominator) and returns the result in lowest
// terms with the sign on the numerator and a status telling a fraction,
// a whole number and an undefined result (zero denominator, returned as 0/0)
// apart. One word is in flight at a time. A word passes through three products
// on the single shared multiplier, a step at a time through the binary gcd
// loop, then through the bit-serial restoring divider that divides numerator
// and denominator by the gcd together. A zero numerator or denominator skips
// gcd and division. A finished result waits in an output register, so the
// next word is taken while it is still unread. Results outside the 33-bit
// numerator or 32-bit denominator range (only possible above 16-bit operands)
// saturate.
module rational_arith_reduce import rar_pkg::*; #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input word
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // num_a, den_a, num_b, den_b, each OPERAND_BITS wide, zero padded to bytes
  input  logic [((4*OPERAND_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // kind
  input  logic [KIND_W-1:0]   s_axis_tuser_i,
  // result word
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // num_out (33), den_out (32), zero padding
  output logic [((NUM_OUT_W+DEN_OUT_W+7)/8)*8-1:0] m_axis_tdata_o,
  // status
  output logic [STATUS_W-1:0] m_axis_tuser_o
);

  localparam int OB    = OPERAND_BITS;
  localparam int OUT_W = ((NUM_OUT_W + DEN_OUT_W + 7) / 8) * 8;
  localparam int PAD_W = OUT_W - NUM_OUT_W - DEN_OUT_W;

  rar_cmd_t cmd;
  rar_sts_t sts;

  logic signed [NUM_OUT_W-1:0] num_out;
  logic        [DEN_OUT_W-1:0] den_out;
  logic        [STATUS_W-1:0]  status;
  logic signed [OB-1:0]        num_a, num_b;

  // unpack the operand fields from the lowest bit up
  assign num_a = s_axis_tdata_i[OB-1:0];
  assign num_b = s_axis_tdata_i[3*OB-1:2*OB];

  // sequencer: multiply steps, gcd loop, divide loop, hand-off to output
  rar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // multiplier, combine, gcd, dividers and the output register
  rar_dp #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (kind_e'(s_axis_tuser_i)),
    .num_a_i     (num_a),
    .den_a_i     (s_axis_tdata_i[2*OB-1:OB]),
    .num_b_i     (num_b),
    .den_b_i     (s_axis_tdata_i[4*OB-1:3*OB]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .num_out_o   (num_out),
    .den_out_o   (den_out),
    .status_o    (status)
  );

  // pack the result, numerator in the lowest bits
  assign m_axis_tdata_o = {{PAD_W{1'b0}}, den_out, num_out};
  assign m_axis_tuser_o = status;

endmodule

FILE: tb/sv/tb_top.sv
module tb_top import rar_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPB   = 16;
  localparam int IN_W  = ((4*OPB+7)/8)*8;
  localparam int OUT_W = ((NUM_OUT_W+DEN_OUT_W+7)/8)*8;
  localparam int N_RANDOM = 900;
  localparam int CALM_TAIL = 80;

  // one operand pair as it travels on the input side
  typedef struct {
    kind_e                  kind;
    logic signed [OPB-1:0]  num_a;
    logic        [OPB-1:0]  den_a;
    logic signed [OPB-1:0]  num_b;
    logic        [OPB-1:0]  den_b;
  } frac_pair_t;

  // reduced fraction as it comes back
  typedef struct {
    logic signed [NUM_OUT_W-1:0] num;
    logic        [DEN_OUT_W-1:0] den;
    logic        [STATUS_W-1:0]  status;
  } frac_res_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i  = '0;   // num_a, den_a, num_b, den_b
  logic [KIND_W-1:0] s_axis_tuser_i  = '0;   // kind
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata_o;         // num_out, den_out, padding
  logic [STATUS_W-1:0] m_axis_tuser_o;       // status

  frac_pair_t pair_q[$];      // operand pairs still to be sent
  frac_res_t  reduced_q[$];   // reduced fractions owed by the block
  frac_pair_t drv_item = '{KIND_ADD, '0, '0, '0, '0};

  logic in_taken = 1'b0;
  logic calm     = 1'b0;
  int   src_gap  = 0;
  int   sink_gap = 0;
  int   err_cnt  = 0;
  int   res_cnt  = 0;
  int   kind_cnt [4] = '{0, 0, 0, 0};
  int   stat_cnt [3] = '{0, 0, 0};

  rational_arith_reduce #(.OPERAND_BITS(OPB)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #4 clk_i = ~clk_i;

  // combine the two fractions and reduce by the gcd
  function automatic frac_res_t reduce_frac(frac_pair_t p);
    logic [OPB-1:0] abs_a, abs_b;
    logic [63:0]    mag_a, mag_b, da, db, x, y, nmag, dmag, t;
    logic           neg_a, neg_b, yneg, nneg, dneg;
    frac_res_t      r;
    neg_a = p.num_a[OPB-1];
    neg_b = p.num_b[OPB-1];
    abs_a = neg_a ? -p.num_a : p.num_a;
    abs_b = neg_b ? -p.num_b : p.num_b;
    mag_a = abs_a;
    mag_b = abs_b;
    da    = p.den_a;
    db    = p.den_b;
    dneg  = 1'b0;
    case (p.kind) inside
      KIND_ADD, KIND_SUB: begin
        x    = mag_a * db;
        y    = mag_b * da;
        yneg = neg_b ^ (p.kind == KIND_SUB);
        if (neg_a == yneg) begin
          nneg = neg_a;
          nmag = x + y;
        end else if (x >= y) begin
          nneg = neg_a;
          nmag = x - y;
        end else begin
          nneg = yneg;
          nmag = y - x;
        end
        dmag = da * db;
      end
      KIND_MUL: begin
        nmag = mag_a * mag_b;
        nneg = neg_a ^ neg_b;
        dmag = da * db;
      end
      default: begin
        nmag = mag_a * db;
        nneg = neg_a;
        dmag = mag_b * da;
        dneg = neg_b;
      end
    endcase
    if (dmag == 0) begin
      r.num    = '0;
      r.den    = '0;
      r.status = STATUS_UNDEF;
      return r;
    end
    nneg = nneg ^ dneg;
    if (nmag == 0) begin
      nneg = 1'b0;
      dmag = 64'd1;
    end else begin
      x = nmag;
      y = dmag;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      nmag = nmag / x;
      dmag = dmag / x;
    end
    // saturation, only reachable with operands wider than 16 bits
    if (nneg && nmag > 64'h1_0000_0000) nmag = 64'h1_0000_0000;
    if (!nneg && nmag > 64'hFFFF_FFFF) nmag = 64'hFFFF_FFFF;
    if (dmag > 64'hFFFF_FFFF) dmag = 64'hFFFF_FFFF;
    t        = nneg ? (~nmag + 64'd1) : nmag;
    r.num    = t[NUM_OUT_W-1:0];
    r.den    = dmag[DEN_OUT_W-1:0];
    r.status = (dmag == 64'd1) ? STATUS_WHOLE : STATUS_FRACTION;
    return r;
  endfunction

  function automatic logic [OPB-1:0] pick_num();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return {1'b1, {(OPB-1){1'b0}}};
          1: return {1'b0, {(OPB-1){1'b1}}};
          2: return '0;
          3: return '1;
          default: return OPB'(1);
        endcase
      end
      1, 2, 3: return OPB'($urandom_range(0, 48)) - OPB'(24);
      default: return OPB'($urandom);
    endcase
  endfunction

  function automatic logic [OPB-1:0] pick_den();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return OPB'(1);
      2: return '1;
      3, 4, 5, 6, 7: return OPB'($urandom_range(1, 36));
      default: return OPB'($urandom);
    endcase
  endfunction

  task automatic add_pair(kind_e k, logic [OPB-1:0] na, logic [OPB-1:0] da,
                          logic [OPB-1:0] nb, logic [OPB-1:0] db);
    frac_pair_t p;
    p.kind  = k;
    p.num_a = na;
    p.den_a = da;
    p.num_b = nb;
    p.den_b = db;
    pair_q.push_back(p);
  endtask

  task automatic flag_mismatch(string what, longint got_v, longint want_v);
    $display("[%0t] mismatch on result %0d: %s got %0d, want %0d",
             $realtime, res_cnt, what, got_v, want_v);
    err_cnt++;
  endtask

  // sender: a word is held until taken, bursts of idle cycles between words
  always @(negedge clk_i) begin
    logic nxt_valid;
    nxt_valid = s_axis_tvalid_i;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (!s_axis_tvalid_i || in_taken) begin
      nxt_valid = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(0, 11);
      end else if (pair_q.size() > 0) begin
        drv_item  = pair_q.pop_front();
        nxt_valid = 1'b1;
      end
    end
    s_axis_tvalid_i <= nxt_valid;
    s_axis_tdata_i  <= IN_W'({drv_item.den_b, drv_item.num_b,
                              drv_item.den_a, drv_item.num_a});
    s_axis_tuser_i  <= drv_item.kind;
  end

  // receiver: bursts of stall cycles, none in the tail of the run
  always @(negedge clk_i) begin
    logic nxt_ready;
    if (calm) begin
      nxt_ready = 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap--;
      nxt_ready = 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      sink_gap  = $urandom_range(0, 11);
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = 1'b1;
    end
    m_axis_tready_i <= nxt_ready;
  end

  // handshakes are sampled on the rising edge
  always @(posedge clk_i) begin
    frac_res_t got, want;
    in_taken <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      reduced_q.push_back(reduce_frac(drv_item));
      kind_cnt[drv_item.kind]++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.num    = m_axis_tdata_o[NUM_OUT_W-1:0];
      got.den    = m_axis_tdata_o[NUM_OUT_W +: DEN_OUT_W];
      got.status = m_axis_tuser_o;
      if (reduced_q.size() == 0) begin
        flag_mismatch("word with nothing outstanding, num_out", got.num, 0);
      end else begin
        want = reduced_q.pop_front();
        if (got.num !== want.num) flag_mismatch("num_out", got.num, want.num);
        if (got.den !== want.den) flag_mismatch("den_out", got.den, want.den);
        if (got.status !== want.status)
          flag_mismatch("status", got.status, want.status);
        stat_cnt[want.status]++;
      end
      res_cnt++;
    end
  end

  initial begin
    // directed: extremes, every operation, zero denominators and numerators
    add_pair(KIND_ADD, 1, 2, 1, 3);
    add_pair(KIND_SUB, 1, 2, 1, 2);
    add_pair(KIND_ADD, -1, 1, 1, 1);
    add_pair(KIND_MUL, -32768, 1, -32768, 1);
    add_pair(KIND_MUL, 32767, 1, 32767, 1);
    add_pair(KIND_MUL, -32768, 16'hFFFF, 32767, 16'hFFFF);
    add_pair(KIND_DIV, 32767, 16'hFFFF, -32768, 16'hFFFF);
    add_pair(KIND_DIV, -1, 16'hFFFF, 1, 16'hFFFF);
    add_pair(KIND_DIV, -6, 4, -3, 2);
    add_pair(KIND_DIV, 5, 7, -3, 11);
    add_pair(KIND_ADD, -32768, 16'hFFFF, -32768, 16'hFFFF);
    add_pair(KIND_SUB, 32767, 16'hFFFF, -32768, 16'hFFFF);
    add_pair(KIND_SUB, -32768, 1, 32767, 1);
    add_pair(KIND_ADD, 2, 4, 6, 8);
    add_pair(KIND_ADD, 3, 0, 4, 5);
    add_pair(KIND_SUB, 3, 5, 4, 0);
    add_pair(KIND_MUL, 7, 9, -2, 0);
    add_pair(KIND_ADD, 0, 0, 0, 0);
    add_pair(KIND_DIV, 3, 4, 0, 9);
    add_pair(KIND_DIV, 0, 4, -5, 9);
    add_pair(KIND_MUL, 0, 3, -5, 7);
    add_pair(KIND_SUB, -4, 6, -4, 6);
    add_pair(KIND_DIV, -32768, 1, 1, 16'hFFFF);
    add_pair(KIND_MUL, -1, 16'hFFFF, -1, 16'hFFFF);
    for (int i = 0; i < N_RANDOM; i++)
      add_pair(kind_e'($urandom_range(0, 3)), pick_num(), pick_den(),
               pick_num(), pick_den());

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pair_q.size() > CALM_TAIL) @(posedge clk_i);
    calm = 1'b1;
    while (pair_q.size() > 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (reduced_q.size() > 0) @(posedge clk_i);
    // room for a stray extra word to show up
    repeat (150) @(posedge clk_i);

    $display("checked %0d results: %0d add, %0d sub, %0d mul, %0d div",
             res_cnt, kind_cnt[KIND_ADD], kind_cnt[KIND_SUB],
             kind_cnt[KIND_MUL], kind_cnt[KIND_DIV]);
    $display("%0d fractions, %0d whole, %0d undefined, %0d mismatches",
             stat_cnt[STATUS_FRACTION], stat_cnt[STATUS_WHOLE],
             stat_cnt[STATUS_UNDEF], err_cnt);
    if (err_cnt == 0) begin
      $display("rational_arith_reduce test passed");
    end else begin
      $display("rational_arith_reduce test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", reduced_q.size());
    $display("rational_arith_reduce test failed");
    $finish;
  end

endmodule

FILE: rational_arith_reduce.f
src/rar_pkg.sv
src/rar_ctrl.sv
src/rar_dp.sv
src/rational_arith_reduce.sv
tb/sv/tb_top.sv
